### hdl/humidity_sensor_frame_decoder_unit_defines.svh
// Assertion macros shared by the frame decoder modules
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_UNIT_DEFINES_SVH

// check a property in the same cycle as its trigger
`define HSFD_ASSERT_SAME(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error(msg);

// check a property in the cycle after its trigger
`define HSFD_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

### hdl/hsfd_pkg.sv
// Types, constants and CRC function of the humidity sensor frame decoder
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FIRST_CRC  = 2'd1;
  localparam logic [1:0] STATUS_SECOND_CRC = 2'd2;

  localparam logic MODE_MEASURE = 1'b0;
  localparam logic MODE_SERIAL  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } hsfd_in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [31:0]        serial_number;
    logic [1:0]         frame_status;
  } hsfd_out_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  status;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } hsfd_frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hsfd_queue_status_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    int i;
    c = crc ^ data;
    for (i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/hsfd_front.sv
// Front end: byte position tracking, CRC check and frame assembly
`default_nettype none

module hsfd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  input  hsfd_pkg::hsfd_in_t          byte_data,
  output logic                        byte_stall,
  input  logic                        frame_mode,
  input  hsfd_pkg::hsfd_queue_status_t queue_status,
  output logic                        push,
  output hsfd_pkg::hsfd_frame_t       push_frame
);
  import hsfd_pkg::*;

  typedef enum logic [2:0] {
    POS_A_HI  = 3'd0,
    POS_A_LO  = 3'd1,
    POS_A_CRC = 3'd2,
    POS_B_HI  = 3'd3,
    POS_B_LO  = 3'd4,
    POS_B_CRC = 3'd5
  } pos_t;

  pos_t        pos;
  pos_t        pos_eff;
  logic [7:0]  crc;
  logic [7:0]  crc_in;
  logic [7:0]  crc_next;
  logic [15:0] first_word;
  logic [7:0]  second_high;
  logic [7:0]  second_low;
  logic        first_bad;
  logic        accept;

  assign byte_stall = queue_status.full;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    pos_eff = pos;
    if (byte_data.frame_start || pos > POS_B_CRC) begin
      pos_eff = POS_A_HI;
    end
    crc_in   = (pos_eff == POS_A_HI || pos_eff == POS_B_HI) ? CRC_INIT : crc;
    crc_next = crc8_byte(crc_in, byte_data.data_byte);
  end

  always_comb begin
    push                   = accept && (pos_eff == POS_B_CRC);
    push_frame.mode        = frame_mode;
    push_frame.first_word  = first_word;
    push_frame.second_word = {second_high, second_low};
    if (first_bad) begin
      push_frame.status = STATUS_FIRST_CRC;
    end else if (crc != byte_data.data_byte) begin
      push_frame.status = STATUS_SECOND_CRC;
    end else begin
      push_frame.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_A_HI;
      crc       <= CRC_INIT;
      first_bad <= 1'b0;
    end else if (accept) begin
      unique case (pos_eff)
        POS_A_HI: begin
          crc        <= crc_next;
          first_word <= {byte_data.data_byte, 8'h00};
          pos        <= POS_A_LO;
        end
        POS_A_LO: begin
          crc        <= crc_next;
          first_word <= {first_word[15:8], byte_data.data_byte};
          pos        <= POS_A_CRC;
        end
        POS_A_CRC: begin
          first_bad <= (crc != byte_data.data_byte);
          crc       <= CRC_INIT;
          pos       <= POS_B_HI;
        end
        POS_B_HI: begin
          crc         <= crc_next;
          second_high <= byte_data.data_byte;
          pos         <= POS_B_LO;
        end
        POS_B_LO: begin
          crc        <= crc_next;
          second_low <= byte_data.data_byte;
          pos        <= POS_B_CRC;
        end
        POS_B_CRC: begin
          crc       <= CRC_INIT;
          first_bad <= 1'b0;
          pos       <= POS_A_HI;
        end
        default: begin
          pos <= POS_A_HI;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/hsfd_queue.sv
// Two-entry frame queue between the front end and the conversion back end
`default_nettype none
`include "humidity_sensor_frame_decoder_unit_defines.svh"

module hsfd_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  hsfd_pkg::hsfd_frame_t        push_frame,
  input  logic                         pop,
  output hsfd_pkg::hsfd_frame_t        head,
  output hsfd_pkg::hsfd_queue_status_t status
);
  import hsfd_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam logic [PW:0] DEPTH_CNT = (PW + 1)'(DEPTH);

  hsfd_frame_t     entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == DEPTH_CNT);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  `HSFD_ASSERT_SAME(a_no_push_full, push, !status.full, "frame pushed into full queue")
  `HSFD_ASSERT_SAME(a_no_pop_empty, pop, !status.empty, "frame popped from empty queue")
  `HSFD_ASSERT_SAME(a_count_range, 1'b1, count <= DEPTH_CNT, "queue count out of range")

endmodule

`default_nettype wire

### hdl/hsfd_back.sv
// Back end: scaling of measurement words, status gating and result register
`default_nettype none
`include "humidity_sensor_frame_decoder_unit_defines.svh"

module hsfd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  hsfd_pkg::hsfd_frame_t        head,
  input  hsfd_pkg::hsfd_queue_status_t queue_status,
  output logic                         pop,
  output logic                         result_valid,
  input  logic                         result_stall,
  output hsfd_pkg::hsfd_out_t          result_data
);
  import hsfd_pkg::*;

  localparam logic [30:0]        TEMP_SCALE  = 31'd17500;
  localparam logic [29:0]        HUM_SCALE   = 30'd12500;
  localparam logic [16:0]        FULL_SCALE  = 17'd65535;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic signed [15:0] HUM_OFFSET  = 16'sd600;
  localparam logic signed [15:0] HUM_MAX     = 16'sd10000;

  logic               advance;
  logic               s1_valid;
  hsfd_frame_t        s1_frame;
  logic [30:0]        s1_temp_prod;
  logic [29:0]        s1_hum_prod;

  logic [14:0]        t_q;
  logic [16:0]        t_sum;
  logic [14:0]        t_ticks;
  logic signed [15:0] t_val;
  logic [13:0]        h_q;
  logic [16:0]        h_sum;
  logic [13:0]        h_ticks;
  logic signed [15:0] h_val;
  logic [13:0]        h_clamped;
  hsfd_out_t          result_next;

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && !queue_status.empty;

  always_comb begin
    t_q     = s1_temp_prod[30:16];
    t_sum   = {2'b00, t_q} + {1'b0, s1_temp_prod[15:0]};
    t_ticks = t_q + 15'(t_sum >= FULL_SCALE);
    t_val   = $signed({1'b0, t_ticks}) - TEMP_OFFSET;

    h_q     = s1_hum_prod[29:16];
    h_sum   = {3'b000, h_q} + {1'b0, s1_hum_prod[15:0]};
    h_ticks = h_q + 14'(h_sum >= FULL_SCALE);
    h_val   = $signed({2'b00, h_ticks}) - HUM_OFFSET;
    priority if (h_val < 16'sd0) begin
      h_clamped = '0;
    end else if (h_val > HUM_MAX) begin
      h_clamped = HUM_MAX[13:0];
    end else begin
      h_clamped = h_val[13:0];
    end

    result_next              = '0;
    result_next.frame_status = s1_frame.status;
    if (s1_frame.status == STATUS_OK) begin
      if (s1_frame.mode == MODE_SERIAL) begin
        result_next.serial_number = {s1_frame.first_word, s1_frame.second_word};
      end else begin
        result_next.temperature_centi = t_val[14:0];
        result_next.humidity_centi    = h_clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= pop;
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_frame     <= head;
      s1_temp_prod <= TEMP_SCALE * 31'(head.first_word);
      s1_hum_prod  <= HUM_SCALE * 30'(head.second_word);
      result_data  <= result_next;
    end
  end

  `HSFD_ASSERT_NEXT(a_pop_fills_stage, pop, s1_valid, "popped frame lost before product stage")
  `HSFD_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid, "product stage dropped under stall")
  `HSFD_ASSERT_SAME(a_error_zeroes, result_valid && result_data.frame_status != STATUS_OK, result_data.temperature_centi == 15'sd0 && result_data.humidity_centi == 14'd0 && result_data.serial_number == 32'd0, "CRC error result carries data")
  `HSFD_ASSERT_SAME(a_hum_clamped, result_valid, result_data.humidity_centi <= HUM_MAX[13:0], "humidity above full scale")

endmodule

`default_nettype wire

### hdl/humidity_sensor_frame_decoder_unit.sv
// Top level of the humidity sensor frame decoder
// Usage:
//   Bytes enter on byte_valid / byte_stall / byte_data, one transaction per
//   byte. byte_data.frame_start marks byte 0 of a six-byte frame (word, CRC,
//   word, CRC) and drops any partial frame. The sixth byte produces one
//   transaction on result_valid / result_stall / result_data; other bytes
//   produce none.
//   frame_mode_we / frame_mode_wdata write the mode: 0 measurement
//   (temperature and humidity in hundredths), 1 serial number. Write it only
//   while no frame is in flight.
//   Throughput: one byte per cycle while byte_stall is low; the CRC byte
//   update is unrolled in the front end and the back end accepts a frame
//   every cycle unless a stalled result holds it. Path: the frame of the
//   sixth byte passes the queue, product register and result register.
//   Stall: a stalled result holds; the back end keeps its product stage and
//   the two-entry frame queue fills, then byte_stall rises until a slot frees.
//   Reset (rst, synchronous): clears byte position, CRC, queue and valids;
//   mode returns to measurement.
`default_nettype none

module humidity_sensor_frame_decoder_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_mode_we,
  input  logic                frame_mode_wdata,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  hsfd_pkg::hsfd_in_t  byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output hsfd_pkg::hsfd_out_t result_data
);
  import hsfd_pkg::*;

  logic               frame_mode;
  logic               push;
  logic               pop;
  hsfd_frame_t        push_frame;
  hsfd_frame_t        head;
  hsfd_queue_status_t queue_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= MODE_MEASURE;
    end else if (frame_mode_we) begin
      frame_mode <= frame_mode_wdata;
    end
  end

  hsfd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data),
    .byte_stall   (byte_stall),
    .frame_mode   (frame_mode),
    .queue_status (queue_status),
    .push         (push),
    .push_frame   (push_frame)
  );

  hsfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .status     (queue_status)
  );

  hsfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .queue_status (queue_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

`default_nettype wire
